### rtl/tsod_pkg.sv
// shared types and constants for the syn option detect table
package tsod_pkg;
  localparam int TableDepthDef = 16;
  localparam int MaxPacketBytesDef = 2048;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [0:0] CFG_CRYPT_KIND = 1'd0;
  localparam logic [0:0] CFG_MAX_AGE    = 1'd1;

  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] lookup_dst_port;
    logic [15:0] lookup_src_port;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        option_found;
    logic        table_full;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        hello_flag;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic tick;
    logic finish;
    logic scan_start;
    logic scan_step;
    logic load_out_lookup;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;
endpackage

### rtl/tsod_if.sv
// valid ready channel interfaces
interface tsod_in_if;
  logic               valid;
  logic               ready;
  tsod_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tsod_out_if;
  logic                valid;
  logic                ready;
  tsod_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tsod_cfg_if;
  logic                valid;
  logic                ready;
  tsod_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/tsod_ctrl.sv
// controller: sequences bytes, ticks and table scans, owns the output valid register
module tsod_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tsod_pkg::in_item_t  in_item,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output tsod_pkg::dp_cmd_t   cmd,
  input  tsod_pkg::dp_sts_t   sts
);
  localparam logic [0:0] ST_RUN  = 1'd0;
  localparam logic [0:0] ST_SCAN = 1'd1;

  logic [0:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc, out_free;

  // a new result may be loaded when the output register is empty or draining
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_RUN) && out_free;
  assign acc = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      ST_RUN: begin
        if (acc) begin
          case (in_item.kind)
            tsod_pkg::KIND_BYTE: begin
              cmd.take_byte = 1'b1;
              if (in_item.last_byte) begin
                cmd.finish = 1'b1;
                out_valid_nxt = 1'b1;
              end
            end
            tsod_pkg::KIND_LOOKUP: begin
              cmd.scan_start = 1'b1;
              state_nxt = ST_SCAN;
            end
            tsod_pkg::KIND_TICK: cmd.tick = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done && out_free) begin
          cmd.load_out_lookup = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

### rtl/tsod_dp.sv
// datapath: header parser, option walker, connection table and result register
module tsod_dp #(
  parameter int TABLE_DEPTH = tsod_pkg::TableDepthDef,
  parameter int MAX_PACKET_BYTES = tsod_pkg::MaxPacketBytesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsod_pkg::in_item_t  in_item,
  input  logic [7:0]          crypt_kind,
  input  logic [7:0]          max_age,
  input  tsod_pkg::dp_cmd_t   cmd,
  output tsod_pkg::dp_sts_t   sts,
  output tsod_pkg::out_item_t out_item
);
  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]    ihl_r, ihl_nxt;
  logic [3:0]    thl_r, thl_nxt;
  logic          bad_r, bad_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [7:0]    okind_r, okind_nxt;
  logic [7:0]    left_r, left_nxt;
  logic          match_r, match_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   ports_r, ports_nxt;
  logic [31:0]   sec_r;

  logic [TABLE_DEPTH-1:0] ev_r;
  logic [31:0] eports_r [TABLE_DEPTH];
  logic [31:0] etime_r  [TABLE_DEPTH];

  logic [CW-1:0] scan_r;
  logic [31:0]   key_r;
  logic          hello_r;
  tsod_pkg::out_item_t out_r;

  // header arithmetic, widths sized for the largest position
  logic [PW+1:0] p, oend;
  logic [7:0]    b;
  logic          in_range;

  assign b = in_item.data_byte;
  assign p = {2'b0, pos_r};
  assign in_range = pos_r < PW'(MAX_PACKET_BYTES);

  always_comb begin
    logic [PW+1:0] tn, hn;
    pos_nxt = pos_r; ihl_nxt = ihl_r; thl_nxt = thl_r; bad_nxt = bad_r;
    ph_nxt = ph_r; okind_nxt = okind_r; left_nxt = left_r; match_nxt = match_r;
    addr_nxt = addr_r; ports_nxt = ports_r;
    oend = '0; tn = '0; hn = '0;
    if (in_range) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == '0) begin
        ihl_nxt = b[3:0];
        if (b[7:4] != 4'd4) bad_nxt = 1'b1;
      end
      if (p == (PW + 2)'(9) && b != 8'd6) bad_nxt = 1'b1;
      if (p >= (PW + 2)'(12) && p <= (PW + 2)'(15)) addr_nxt = {addr_r[23:0], b};
      // offset uses the ihl taken from this byte when position is zero
      tn = (PW + 2)'({ihl_nxt, 2'b00});
      if (p >= tn && p <= tn + 3) ports_nxt = {ports_r[23:0], b};
      if (p == tn + 12) thl_nxt = b[7:4];
      if (p == tn + 13 && b != 8'h02) bad_nxt = 1'b1;
      hn = tn + (PW + 2)'({thl_nxt, 2'b00});
      if (p >= tn + 20 && p < hn) begin
        unique case (ph_r)
          tsod_pkg::PH_KIND: begin
            okind_nxt = b;
            if (b > 8'd1) ph_nxt = tsod_pkg::PH_LEN;
          end
          tsod_pkg::PH_LEN: begin
            oend = p - (PW + 2)'(1) + (PW + 2)'(b);
            if (b < 8'd2 || oend > hn) begin
              ph_nxt = tsod_pkg::PH_STOP;
            end else begin
              if (okind_r == crypt_kind) match_nxt = 1'b1;
              left_nxt = b - 8'd2;
              ph_nxt = (b == 8'd2) ? tsod_pkg::PH_KIND : tsod_pkg::PH_BODY;
            end
          end
          tsod_pkg::PH_BODY: begin
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) ph_nxt = tsod_pkg::PH_KIND;
          end
          default: ;
        endcase
      end
    end
  end

  // verdict after this byte
  logic [PW+1:0] fin_hend;
  logic          found, full;
  logic [IW-1:0] slot;
  logic          have_slot;
  assign fin_hend = (PW + 2)'({ihl_nxt, 2'b00}) + (PW + 2)'({thl_nxt, 2'b00});
  assign found = !bad_nxt && match_nxt && fin_hend <= {2'b0, pos_nxt};

  always_comb begin
    slot = '0;
    have_slot = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!ev_r[i]) begin
        slot = IW'(i);
        have_slot = 1'b1;
      end
    end
  end
  assign full = found && !have_slot;

  logic [IW-1:0] si;
  logic [31:0]   age;
  assign si = scan_r[IW-1:0];
  assign age = sec_r - etime_r[si];
  assign sts.scan_done = (scan_r == CW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; ihl_r <= '0; thl_r <= '0; bad_r <= 1'b0;
      ph_r <= tsod_pkg::PH_KIND; okind_r <= '0; left_r <= '0; match_r <= 1'b0;
      addr_r <= '0; ports_r <= '0; sec_r <= '0; ev_r <= '0;
      scan_r <= '0; hello_r <= 1'b0;
    end else begin
      if (cmd.tick) sec_r <= sec_r + 32'd1;
      if (cmd.take_byte) begin
        if (cmd.finish) begin
          pos_r <= '0; ihl_r <= '0; thl_r <= '0; bad_r <= 1'b0;
          ph_r <= tsod_pkg::PH_KIND; okind_r <= '0; left_r <= '0; match_r <= 1'b0;
          addr_r <= '0; ports_r <= '0;
          if (found && have_slot) ev_r[slot] <= 1'b1;
        end else begin
          pos_r <= pos_nxt; ihl_r <= ihl_nxt; thl_r <= thl_nxt; bad_r <= bad_nxt;
          ph_r <= ph_nxt; okind_r <= okind_nxt; left_r <= left_nxt;
          match_r <= match_nxt; addr_r <= addr_nxt; ports_r <= ports_nxt;
        end
      end
      if (cmd.scan_start) begin
        scan_r <= '0;
        hello_r <= 1'b0;
      end else if (cmd.scan_step && !sts.scan_done) begin
        scan_r <= scan_r + 1'b1;
        if (ev_r[si]) begin
          if (eports_r[si] == key_r) hello_r <= 1'b1;
          // matching or stale entries are dropped
          if (eports_r[si] == key_r || age > {24'd0, max_age}) ev_r[si] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) key_r <= {in_item.lookup_src_port, in_item.lookup_dst_port};
    if (cmd.take_byte && cmd.finish && found && have_slot) begin
      eports_r[slot] <= ports_nxt;
      etime_r[slot] <= sec_r;
    end
    if (cmd.take_byte && cmd.finish) begin
      out_r.result_kind <= 1'b0;
      out_r.option_found <= found;
      out_r.table_full <= full;
      out_r.source_address <= addr_nxt;
      out_r.source_port <= ports_nxt[31:16];
      out_r.dest_port <= ports_nxt[15:0];
      out_r.hello_flag <= 1'b0;
    end else if (cmd.load_out_lookup) begin
      out_r <= {1'b1, 1'b0, 1'b0, 32'd0, 16'd0, 16'd0, hello_r};
    end
  end

  assign out_item = out_r;
endmodule

### rtl/tcp_syn_option_detect_table.sv
// top level of the syn option detect table
//  channel | dir | payload
//  in_     | in  | kind, data_byte, last_byte, lookup ports
//  out_    | out | verdict or lookup answer
//  cfg_    | in  | register index and write data
// packet bytes are taken one byte per cycle, as are ticks, while in_ready is high
// a lookup scans one table entry per cycle, then loads its answer once the output register is free
// rst_n is synchronous; table valid bits clear at once, no clearing pass
// a full output register stalls the input until it is taken
module tcp_syn_option_detect_table #(
  parameter int TABLE_DEPTH = tsod_pkg::TableDepthDef,
  parameter int MAX_PACKET_BYTES = tsod_pkg::MaxPacketBytesDef
) (
  input logic     clk,
  input logic     rst_n,
  tsod_in_if.sink   in_ch,
  tsod_out_if.source out_ch,
  tsod_cfg_if.sink  cfg_ch
);
  logic [7:0] crypt_kind_r, max_age_r;
  tsod_pkg::dp_cmd_t cmd;
  tsod_pkg::dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crypt_kind_r <= 8'd69;
      max_age_r <= 8'd10;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.kind)
        2'(tsod_pkg::CFG_CRYPT_KIND): crypt_kind_r <= cfg_ch.payload.data;
        2'(tsod_pkg::CFG_MAX_AGE):    max_age_r <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

  tsod_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_item(in_ch.payload), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .cmd, .sts
  );

  tsod_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_dp (
    .clk, .rst_n, .in_item(in_ch.payload), .crypt_kind(crypt_kind_r),
    .max_age(max_age_r), .cmd, .sts, .out_item(out_ch.payload)
  );

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !in_ch.ready) else $error("input taken during scan");
  a_lookup_answer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out_lookup |=> out_ch.valid && out_ch.payload.result_kind)
    else $error("lookup answer not presented");
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid && !out_ch.payload.result_kind)
    else $error("verdict not presented");
endmodule
